// ===== design/mqmb_pkg.sv =====
// ----------------------------------------------------------------------------
// Mailbox package
// Request and status codes plus default sizing for the multi-queue mailbox.
// ----------------------------------------------------------------------------
package mqmb_pkg;

  localparam int unsigned DefNumQueues  = 8;
  localparam int unsigned DefSlotDepth  = 16;
  localparam int unsigned DefMessageBits = 32;

  // Fixed port widths
  localparam int unsigned ReqTypeW  = 2;
  localparam int unsigned QueueIdW  = 3;
  localparam int unsigned CapW      = 5;
  localparam int unsigned MsgPortW  = 32;
  localparam int unsigned StatusW   = 2;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_CREATE = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_POST   = 2'd2,
    REQ_GET    = 2'd3
  } req_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOFREE = 2'd3
  } status_e;

  typedef struct packed {
    req_kind_e             kind;
    logic [QueueIdW-1:0]   qid;
    logic [CapW-1:0]       cap;
    logic [MsgPortW-1:0]   msg;
  } req_t;

endpackage

// ===== design/multi_queue_mailbox_top.sv =====
// ----------------------------------------------------------------------------
// Multi-queue mailbox
// Bank of ring-buffer message queues sharing one message store. Requests
// create, delete, post to or get from a queue; one result per request.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | to block  | in_valid_i / in_ready_o    | req_type_i queue_id_i capacity_i
//          |           |                            | message_in_i
//  out     | from block| out_valid_o / out_ready_i  | status_o new_queue_id_o
//          |           |                            | message_out_o
//
//  One request per cycle sustained while out_ready_i is not held low; a request
//  passes the request register, then the result register, to reach the output.
//  The figure is set by the single read-modify-write of one queue's pointers
//  and the one store port used per request.
//  Reset clears the in-use map and all pointers, counts and capacities; the
//  message store is not cleared and needs no clearing pass.
//  A stalled result holds; the request stage still advances into the result
//  register as soon as out_ready_i frees it.
//
module multi_queue_mailbox_top
  import mqmb_pkg::*;
#(
  parameter int unsigned NUM_QUEUES   = DefNumQueues,
  parameter int unsigned SLOT_DEPTH   = DefSlotDepth,
  parameter int unsigned MESSAGE_BITS = DefMessageBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ReqTypeW-1:0] req_type_i,
  input  logic [QueueIdW-1:0] queue_id_i,
  input  logic [CapW-1:0]     capacity_i,
  input  logic [MsgPortW-1:0] message_in_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [QueueIdW-1:0] new_queue_id_o,
  output logic [MsgPortW-1:0] message_out_o
);

  // Queue index, slot, count and store address widths
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned SW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SLOT_DEPTH + 1);
  localparam int unsigned StoreDepth = NUM_QUEUES * SLOT_DEPTH;
  localparam int unsigned AW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  // Bits above the port width are always zero, so they are not stored
  localparam int unsigned StoreW = (MESSAGE_BITS < MsgPortW) ? MESSAGE_BITS : MsgPortW;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic in_vld_q, out_vld_q;
  logic out_free, s1_fire;
  req_t req_q;

  assign out_free   = !out_vld_q || out_ready_i;
  assign s1_fire    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Request register (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= '{kind: req_kind_e'(req_type_i), qid: queue_id_i,
                 cap: capacity_i, msg: message_in_i};
    end
  end

  // --------------------------------------------------------------------------
  // Queue state: in-use map and per-queue pointers
  // --------------------------------------------------------------------------
  logic [NUM_QUEUES-1:0] in_use_q, in_use_d;
  logic [SW-1:0]         rd_slot_q [NUM_QUEUES];
  logic [SW-1:0]         rd_slot_d [NUM_QUEUES];
  logic [SW-1:0]         wr_slot_q [NUM_QUEUES];
  logic [SW-1:0]         wr_slot_d [NUM_QUEUES];
  logic [CW-1:0]         fill_q    [NUM_QUEUES];
  logic [CW-1:0]         fill_d    [NUM_QUEUES];
  logic [CW-1:0]         cap_q     [NUM_QUEUES];
  logic [CW-1:0]         cap_d     [NUM_QUEUES];

  logic          q_ok;
  logic [QW-1:0] qsel;
  logic [CW-1:0] cap_sel, fill_sel, cap_sat;
  logic [SW-1:0] rs_sel, ws_sel, slot_sel, rs_nxt, ws_nxt;
  logic [CW-1:0] rs_inc, ws_inc;
  logic          is_full, is_empty;
  logic          free_found;
  logic [QW-1:0] free_idx;
  logic [AW-1:0] mem_addr;
  logic          mem_we, mem_re;
  status_e       status_d;
  logic [QueueIdW-1:0] new_id_d;

  assign q_ok     = (32'(req_q.qid) < NUM_QUEUES);
  assign qsel     = QW'(req_q.qid);
  assign cap_sel  = cap_q[qsel];
  assign fill_sel = fill_q[qsel];
  assign rs_sel   = rd_slot_q[qsel];
  assign ws_sel   = wr_slot_q[qsel];

  assign cap_sat  = (32'(req_q.cap) > SLOT_DEPTH) ? CW'(SLOT_DEPTH) : CW'(req_q.cap);

  // Unused queues carry capacity 0, so they fall out as full / empty
  assign is_full  = !q_ok || (fill_sel >= cap_sel);
  assign is_empty = !q_ok || (fill_sel == '0);

  // Slot advance with wrap at the queue's capacity
  assign rs_inc = CW'(rs_sel) + CW'(1);
  assign ws_inc = CW'(ws_sel) + CW'(1);
  assign rs_nxt = (rs_inc >= cap_sel) ? '0 : SW'(rs_inc);
  assign ws_nxt = (ws_inc >= cap_sel) ? '0 : SW'(ws_inc);

  // Lowest free queue
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = QW'(i);
      end
    end
  end

  assign slot_sel = (req_q.kind == REQ_POST) ? ws_sel : rs_sel;
  assign mem_addr = AW'(32'(qsel) * SLOT_DEPTH + 32'(slot_sel));
  assign mem_we   = s1_fire && (req_q.kind == REQ_POST) && !is_full;
  assign mem_re   = s1_fire && (req_q.kind == REQ_GET) && !is_empty;

  always_comb begin
    in_use_d  = in_use_q;
    rd_slot_d = rd_slot_q;
    wr_slot_d = wr_slot_q;
    fill_d    = fill_q;
    cap_d     = cap_q;
    status_d  = ST_OK;
    new_id_d  = '0;
    case (req_q.kind)
      REQ_CREATE: begin
        if (free_found) begin
          in_use_d[free_idx]  = 1'b1;
          rd_slot_d[free_idx] = '0;
          wr_slot_d[free_idx] = '0;
          fill_d[free_idx]    = '0;
          cap_d[free_idx]     = cap_sat;
          new_id_d            = QueueIdW'(free_idx);
        end else begin
          status_d = ST_NOFREE;
        end
      end
      REQ_DELETE: begin
        if (q_ok) begin
          in_use_d[qsel]  = 1'b0;
          rd_slot_d[qsel] = '0;
          wr_slot_d[qsel] = '0;
          fill_d[qsel]    = '0;
          cap_d[qsel]     = '0;
        end
      end
      REQ_POST: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          wr_slot_d[qsel] = ws_nxt;
          fill_d[qsel]    = fill_sel + CW'(1);
        end
      end
      REQ_GET: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_slot_d[qsel] = rs_nxt;
          fill_d[qsel]    = fill_sel - CW'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_slot_q[i] <= '0;
        wr_slot_q[i] <= '0;
        fill_q[i]    <= '0;
        cap_q[i]     <= '0;
      end
    end else if (s1_fire) begin
      in_use_q  <= in_use_d;
      rd_slot_q <= rd_slot_d;
      wr_slot_q <= wr_slot_d;
      fill_q    <= fill_d;
      cap_q     <= cap_d;
    end
  end

  // --------------------------------------------------------------------------
  // Message store: one port, registered read
  // --------------------------------------------------------------------------
  logic [StoreW-1:0] store_mem [StoreDepth];
  logic [StoreW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= req_q.msg[StoreW-1:0];
    end
    if (mem_re) begin
      rd_data_q <= store_mem[mem_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  status_e             status_q;
  logic [QueueIdW-1:0] new_id_q;
  logic                msg_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_vld_q <= 1'b0;
    end else if (s1_fire) begin
      msg_vld_q <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      status_q <= status_d;
      new_id_q <= new_id_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = status_q;
  assign new_queue_id_o = new_id_q;
  assign message_out_o  = msg_vld_q ? MsgPortW'(rd_data_q) : '0;

`ifndef SYNTHESIS
  // Occupancy never exceeds the queue's capacity
  a_fill_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && q_ok) |-> (fill_sel <= cap_sel))
    else $error("fill count above capacity");

  // A free queue holds no capacity and no messages
  a_free_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && q_ok && !in_use_q[qsel]) |-> (cap_sel == '0 && fill_sel == '0))
    else $error("free queue not cleared");

  // A successful create marks the chosen queue as in use
  a_create_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && req_q.kind == REQ_CREATE && free_found) |=> in_use_q[$past(free_idx)])
    else $error("created queue not marked in use");

  // Input stalls only behind a held request and a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("request channel stalled without cause");

  // A message is only returned for a get that found data
  a_msg_only_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && msg_vld_q) |-> (status_q == ST_OK))
    else $error("message returned with error status");
`endif

endmodule

// ===== bench/mailbox_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox checker
// Watches both channels of the mailbox, keeps its own copy of the queue bank,
// works out the result of every accepted request and compares each result
// that leaves the block against the oldest outstanding one.
// ----------------------------------------------------------------------------
module mailbox_checker
  import mqmb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [ReqTypeW-1:0] req_type_i,
  input  logic [QueueIdW-1:0] queue_id_i,
  input  logic [CapW-1:0]     capacity_i,
  input  logic [MsgPortW-1:0] message_in_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [StatusW-1:0]  status_i,
  input  logic [QueueIdW-1:0] new_queue_id_i,
  input  logic [MsgPortW-1:0] message_out_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    status_e             status;
    logic [QueueIdW-1:0] new_id;
    logic [MsgPortW-1:0] msg;
  } reply_t;

  logic [DefNumQueues-1:0] queue_live;
  int unsigned             rd_slot [DefNumQueues];
  int unsigned             wr_slot [DefNumQueues];
  int unsigned             fill    [DefNumQueues];
  int unsigned             cap_of  [DefNumQueues];
  logic [MsgPortW-1:0]     store   [DefNumQueues*DefSlotDepth];
  reply_t                  awaited_replies [$];

  function automatic void clear_queue_state(int unsigned q);
    rd_slot[q] = 0;
    wr_slot[q] = 0;
    fill[q]    = 0;
    cap_of[q]  = 0;
  endfunction

  // Applies one request to the shadow bank and returns its result
  function automatic reply_t serve_request(req_kind_e kind, logic [QueueIdW-1:0] qid,
                                           logic [CapW-1:0] cap, logic [MsgPortW-1:0] msg);
    reply_t      r;
    int unsigned q;
    int unsigned slot;
    int unsigned i;
    r.status = ST_OK;
    r.new_id = '0;
    r.msg    = '0;
    q = qid;
    case (kind)
      REQ_CREATE: begin
        r.status = ST_NOFREE;
        for (i = 0; i < DefNumQueues; i++) begin
          if (!queue_live[i] && r.status == ST_NOFREE) begin
            queue_live[i] = 1'b1;
            clear_queue_state(i);
            cap_of[i] = (cap > DefSlotDepth) ? DefSlotDepth : cap;
            r.status  = ST_OK;
            r.new_id  = QueueIdW'(i);
          end
        end
      end
      REQ_DELETE: begin
        if (q < DefNumQueues) begin
          queue_live[q] = 1'b0;
          clear_queue_state(q);
        end
      end
      REQ_POST: begin
        if (q >= DefNumQueues || fill[q] >= cap_of[q]) begin
          r.status = ST_FULL;
        end else begin
          slot = wr_slot[q] % DefSlotDepth;
          store[q*DefSlotDepth + slot] = msg;
          slot++;
          if (slot >= cap_of[q]) slot = 0;
          wr_slot[q] = slot;
          fill[q]++;
        end
      end
      REQ_GET: begin
        if (q >= DefNumQueues || fill[q] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot  = rd_slot[q] % DefSlotDepth;
          r.msg = store[q*DefSlotDepth + slot];
          slot++;
          if (slot >= cap_of[q]) slot = 0;
          rd_slot[q] = slot;
          fill[q]--;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    int unsigned q;
    if (!rst_ni) begin
      queue_live = '0;
      for (q = 0; q < DefNumQueues; q++) clear_queue_state(q);
      awaited_replies.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        awaited_replies.push_back(serve_request(req_kind_e'(req_type_i), queue_id_i,
                                                capacity_i, message_in_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_replies.size() == 0) begin
          $error("result with no request outstanding: status %0d", status_i);
          fail_count_o++;
        end else begin
          want = awaited_replies.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (new_queue_id_i !== want.new_id) begin
            $error("new_queue_id: expected %0d, got %0d", want.new_id, new_queue_id_i);
            fail_count_o++;
          end
          if (message_out_i !== want.msg) begin
            $error("message_out: expected %0h, got %0h", want.msg, message_out_i);
            fail_count_o++;
          end
        end
      end
      pending_o = awaited_replies.size();
    end
  end

endmodule

// ===== bench/tb_multi_queue_mailbox_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox testbench
// Drives create, delete, post and get requests into the mailbox: a directed
// opening, then randomised traffic under three idling patterns, with a long
// result stall and drain pauses. Checking is done by the mailbox checker.
// ----------------------------------------------------------------------------
module tb_multi_queue_mailbox_top;
  import mqmb_pkg::*;

  localparam int unsigned HoldCycles  = 200;  // long receiver stall
  localparam int unsigned SettleTicks = 8;    // pause before the final verdict

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ReqTypeW-1:0] req_type;
  logic [QueueIdW-1:0] queue_id;
  logic [CapW-1:0]     capacity;
  logic [MsgPortW-1:0] message_in;
  logic                out_valid;
  logic                out_ready;
  logic [StatusW-1:0]  status;
  logic [QueueIdW-1:0] new_queue_id;
  logic [MsgPortW-1:0] message_out;
  int unsigned         fail_count;
  int unsigned         pending;

  // idling odds, in percent, and the stall request flag
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_go;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  multi_queue_mailbox_top DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .queue_id_i     (queue_id),
    .capacity_i     (capacity),
    .message_in_i   (message_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .new_queue_id_o (new_queue_id),
    .message_out_o  (message_out)
  );

  mailbox_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .req_type_i     (req_type),
    .queue_id_i     (queue_id),
    .capacity_i     (capacity),
    .message_in_i   (message_in),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .new_queue_id_i (new_queue_id),
    .message_out_i  (message_out),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Result side: random back-pressure at the falling edge. A stall request
  // holds ready low for a fixed stretch, counted here, so the request side
  // backs up and in_ready drops. The stall is served once.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        repeat (HoldCycles) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request and returns at the falling edge after it is taken.
  // Idle cycles are inserted first, one coin toss per cycle.
  task automatic send_request(input req_kind_e kind, input logic [QueueIdW-1:0] qid,
                              input logic [CapW-1:0] cap, input logic [MsgPortW-1:0] msg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    queue_id   <= qid;
    capacity   <= cap;
    message_in <= msg;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Sender pauses until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly small capacities so queues fill and wrap; zero and oversized now and then
  function automatic logic [CapW-1:0] pick_capacity();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8)  return '0;
    if (roll < 75) return CapW'($urandom_range(1, 6));
    if (roll < 88) return CapW'($urandom_range(7, 16));
    return CapW'($urandom_range(17, 31));
  endfunction

  // Random traffic: fill-then-drain bursts on one queue, mixed with single
  // requests of every kind. Creates outpace deletes so the bank runs out of
  // free queues regularly.
  task automatic random_traffic(input int unsigned count);
    int unsigned         sent;
    int unsigned         burst;
    int unsigned         roll;
    req_kind_e           kind;
    logic [QueueIdW-1:0] qid;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 25) begin
        qid   = QueueIdW'($urandom_range(0, 3));
        burst = $urandom_range(1, 8);
        repeat (burst) send_request(REQ_POST, qid, pick_capacity(), $urandom);
        repeat (burst) send_request(REQ_GET, qid, pick_capacity(), $urandom);
        sent += 2 * burst;
      end else begin
        roll = $urandom_range(99);
        if (roll < 14)      kind = REQ_CREATE;
        else if (roll < 22) kind = REQ_DELETE;
        else if (roll < 62) kind = REQ_POST;
        else                kind = REQ_GET;
        if ($urandom_range(99) < 70) qid = QueueIdW'($urandom_range(0, 3));
        else                         qid = QueueIdW'($urandom_range(0, 7));
        send_request(kind, qid, pick_capacity(), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    in_valid      = 1'b0;
    req_type      = REQ_CREATE;
    queue_id      = '0;
    capacity      = '0;
    message_in    = '0;
    hold_go       = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 46;
    rst_n         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: free queue access, zero and oversized capacity, exhaustion
    send_request(REQ_GET,    3'd0, 5'd0,  32'h0);         // free queue: empty
    send_request(REQ_POST,   3'd0, 5'd0,  32'hFFFF_FFFF); // free queue: full
    send_request(REQ_DELETE, 3'd7, 5'd0,  32'h0);         // delete of a free queue
    send_request(REQ_CREATE, 3'd0, 5'd0,  32'h0);         // q0, no slots
    send_request(REQ_POST,   3'd0, 5'd0,  32'h1234_5678); // zero capacity: full
    send_request(REQ_GET,    3'd0, 5'd0,  32'h0);         // zero capacity: empty
    send_request(REQ_CREATE, 3'd0, 5'd31, 32'h0);         // q1, clamped to depth
    send_request(REQ_CREATE, 3'd0, 5'd1,  32'h0);         // q2, one slot
    send_request(REQ_POST,   3'd2, 5'd0,  32'hFFFF_FFFF);
    send_request(REQ_POST,   3'd2, 5'd0,  32'h0);         // full
    send_request(REQ_GET,    3'd2, 5'd0,  32'h0);
    send_request(REQ_GET,    3'd2, 5'd0,  32'h0);         // empty
    send_request(REQ_CREATE, 3'd0, 5'd16, 32'h0);
    send_request(REQ_CREATE, 3'd0, 5'd2,  32'h0);
    send_request(REQ_CREATE, 3'd0, 5'd17, 32'h0);
    send_request(REQ_CREATE, 3'd0, 5'd3,  32'h0);
    send_request(REQ_CREATE, 3'd0, 5'd4,  32'h0);         // bank now full
    send_request(REQ_CREATE, 3'd0, 5'd5,  32'h0);         // no free queue
    send_request(REQ_DELETE, 3'd0, 5'd0,  32'h0);
    send_request(REQ_CREATE, 3'd0, 5'd2,  32'h0);         // lowest free is q0 again
    send_request(REQ_POST,   3'd1, 5'd0,  32'h0);
    send_request(REQ_POST,   3'd1, 5'd0,  32'h5555_AAAA);
    send_request(REQ_GET,    3'd1, 5'd0,  32'h0);
    send_request(REQ_GET,    3'd1, 5'd0,  32'h0);
    send_request(REQ_DELETE, 3'd4, 5'd0,  32'h0);

    // phase one: sender idles less than receiver, with one long result stall
    random_traffic(60);
    hold_go = 1'b1;
    random_traffic(190);
    wait_drained();

    // phase two: the other way round
    send_idle_pct = 46;
    recv_idle_pct = 33;
    random_traffic(250);
    wait_drained();

    // phase three: full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(250);
    wait_drained();
    repeat (SettleTicks) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== multi_queue_mailbox_top.f =====
design/mqmb_pkg.sv
design/multi_queue_mailbox_top.sv
bench/mailbox_checker.sv
bench/tb_multi_queue_mailbox_top.sv
